/* design/tcns_pkg.sv */
`timescale 1ns / 1ps
package tcns_pkg;

	localparam int unsigned BufPackets = 64;
	localparam int unsigned PidEntries = 8192;
	localparam int unsigned PidW       = 13;
	localparam int unsigned PcrW       = 42;
	localparam int unsigned PnW        = 48;
	localparam int unsigned CntW       = $clog2(BufPackets);
	localparam int unsigned DvdW       = 84;
	localparam int unsigned DenW       = 64;

	localparam logic [31:0] ObrReset   = 32'd40000000;
	localparam logic [35:0] BitsClock  = 36'd40608000000;
	localparam logic [10:0] PktBits    = 11'd1504;
	localparam logic [63:0] PcrModulus = 64'd2576980377600;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_RATE = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;
	localparam logic [1:0] STAT_ZERO = 2'd3;

	typedef struct packed {
		logic [PidW-1:0] pid;
		logic            has_pcr;
		logic [PcrW-1:0] pcr;
	} desc_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_LOOK, ST_MUL, ST_DIVR_S, ST_DIVR_W, ST_CHK,
		ST_STEP, ST_DIVC_S, ST_DIVC_W, ST_EMIT, ST_FIN, ST_BUF, ST_ERR
	} state_t;

endpackage

/* design/ts_cbr_null_stuffing_scheduler.sv */
`timescale 1ns / 1ps
// Channel      Signals                                         Direction
// descriptor   push/full, packet_pid, adaptation_*, pcr_raw    in
// schedule     pop/empty, slot_number, null_count, last, stat  out
// config       cfg_wr_en, cfg_wr_data (output_bitrate)         in
// Packet without PCR: taken, then buffered; first PCR of a PID: table read, lookup, store, buffered.
// PCR flush: multiply, then the rate division, then a division for each released packet
// (skipped when the rate is zero), all on the shared 84-step divider.
// After reset the PID tables are cleared, all 8192 entries, with full high.
// Two descriptors queue ahead of the scheduler; one result waits at the output.
module ts_cbr_null_stuffing_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [12:0] packet_pid,
	input  logic [7:0]  adaptation_control,
	input  logic [7:0]  adaptation_length,
	input  logic [7:0]  adaptation_flags,
	input  logic [47:0] pcr_raw_bytes,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  slot_number,
	output logic [31:0] null_count,
	output logic        last_of_flush,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import tcns_pkg::*;

	logic  fq_valid, fq_pop, clearing;
	desc_t fq_data;

	tcns_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.packet_pid         (packet_pid),
		.adaptation_control (adaptation_control),
		.adaptation_length  (adaptation_length),
		.adaptation_flags   (adaptation_flags),
		.pcr_raw_bytes      (pcr_raw_bytes),
		.clearing           (clearing),
		.fq_valid           (fq_valid),
		.fq_data            (fq_data),
		.fq_pop             (fq_pop)
	);

	tcns_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fq_valid      (fq_valid),
		.fq_data       (fq_data),
		.fq_pop        (fq_pop),
		.clearing      (clearing),
		.empty         (empty),
		.pop           (pop),
		.slot_number   (slot_number),
		.null_count    (null_count),
		.last_of_flush (last_of_flush),
		.status        (status)
	);
endmodule

/* design/tcns_front.sv */
`timescale 1ns / 1ps
module tcns_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [12:0]           packet_pid,
	input  logic [7:0]            adaptation_control,
	input  logic [7:0]            adaptation_length,
	input  logic [7:0]            adaptation_flags,
	input  logic [47:0]           pcr_raw_bytes,
	input  logic                  clearing,
	output logic                  fq_valid,
	output tcns_pkg::desc_t       fq_data,
	input  logic                  fq_pop
);
	import tcns_pkg::*;

	desc_t      q_mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	desc_t      d;
	logic [32:0] base;
	logic       wr_en, rd_en;

	always_comb begin
		base      = pcr_raw_bytes[47:15];
		d.pid     = packet_pid;
		d.has_pcr = adaptation_control[5] & (|adaptation_length) & adaptation_flags[4];
		d.pcr     = ({9'b0, base} << 8) + ({9'b0, base} << 5) + ({9'b0, base} << 3)
			+ ({9'b0, base} << 2) + {33'b0, pcr_raw_bytes[8:0]};
	end

	assign full     = (cnt_q == 2'd2) | clearing;
	assign wr_en    = push & ~full;
	assign fq_valid = (cnt_q != 2'd0);
	assign rd_en    = fq_pop & fq_valid;
	assign fq_data  = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= ~wr_q;
			if (rd_en) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

/* design/tcns_div.sv */
`timescale 1ns / 1ps
module tcns_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [83:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [83:0] quotient,
	output logic [63:0] remainder
);
	import tcns_pkg::*;

	logic [DvdW-1:0] dvd_q;
	logic [DenW-1:0] den_q, rem_q;
	logic [6:0]      cnt_q;
	logic            busy_q, done_q;
	logic [DenW:0]   rem_ext, rem_sub;
	logic            ge;

	always_comb begin
		rem_ext = {rem_q, dvd_q[DvdW-1]};
		ge      = rem_ext >= {1'b0, den_q};
		rem_sub = rem_ext - {1'b0, den_q};
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DenW-1:0] : rem_ext[DenW-1:0];
			dvd_q <= {dvd_q[DvdW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= 7'(DvdW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* design/tcns_back.sv */
`timescale 1ns / 1ps
module tcns_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data,
	input  logic            fq_valid,
	input  tcns_pkg::desc_t fq_data,
	output logic            fq_pop,
	output logic            clearing,
	output logic            empty,
	input  logic            pop,
	output logic [5:0]      slot_number,
	output logic [31:0]     null_count,
	output logic            last_of_flush,
	output logic [1:0]      status
);
	import tcns_pkg::*;

	state_t state_q, state_d;

	logic [PcrW-1:0] pcr_mem [PidEntries];
	logic [PnW-1:0]  pn_mem  [PidEntries];
	logic [PcrW-1:0] old_pcr_q;
	logic [PnW-1:0]  old_pn_q;
	logic            mem_we;
	logic [PidW-1:0] mem_addr;
	logic [PcrW-1:0] mem_wpcr;
	logic [PnW-1:0]  mem_wpn;

	logic [PidW-1:0] clr_q, pid_q;
	logic [PcrW-1:0] pcr_q;
	logic [31:0]     obr_q;
	logic [PnW-1:0]  counter_q, dpk_q;
	logic [63:0]     delta_q, delta_c, free_q, used_q, step_o_q, step_i_q, rate_c;
	logic [DvdW-1:0] prod_q;
	logic [1:0]      mcnt_q;
	logic [CntW-1:0] buf_cnt_q, k_q;
	logic [31:0]     nulls_q;
	logic            halted_q;
	logic [1:0]      err_code_q, err_code_d;
	logic            last_c;

	logic            div_start, div_done;
	logic [DvdW-1:0] div_dvd, div_q;
	logic [DenW-1:0] div_den, div_rem;
	logic [63:0]     cdiff;

	logic            out_valid_q, out_space, out_load;
	logic [5:0]      out_slot_d;
	logic [31:0]     out_nulls_d;
	logic            out_last_d;
	logic [1:0]      out_stat_d;

	tcns_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_rem)
	);

	always_comb begin
		delta_c = ({22'b0, pcr_q} >= {22'b0, old_pcr_q})
			? {22'b0, pcr_q} - {22'b0, old_pcr_q}
			: {22'b0, pcr_q} + PcrModulus - {22'b0, old_pcr_q};
		rate_c  = (div_q[DvdW-1:64] != '0) ? '1 : div_q[63:0];
		cdiff   = free_q - used_q;
		last_c  = ({1'b0, k_q} + 7'd1) == {1'b0, buf_cnt_q};
		div_dvd = (state_q == ST_DIVR_S) ? prod_q : {20'b0, cdiff};
		div_den = (state_q == ST_DIVR_S) ? delta_q : step_i_q;
	end

	assign out_space = ~out_valid_q | pop;
	assign clearing  = (state_q == ST_CLEAR);

	always_comb begin
		state_d     = state_q;
		fq_pop      = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		mem_we      = 1'b0;
		mem_addr    = pid_q;
		mem_wpcr    = pcr_q;
		mem_wpn     = counter_q;
		err_code_d  = STAT_OK;
		out_slot_d  = 6'(k_q);
		out_nulls_d = nulls_q;
		out_last_d  = last_c;
		out_stat_d  = STAT_OK;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				mem_wpcr = '0;
				mem_wpn  = '0;
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (fq_valid) begin
					fq_pop = 1'b1;
					if (!halted_q) state_d = fq_data.has_pcr ? ST_RD : ST_BUF;
				end
			end
			ST_RD: state_d = ST_LOOK;
			ST_LOOK: begin
				if (old_pcr_q == '0) begin
					mem_we  = 1'b1;
					state_d = ST_BUF;
				end else if (delta_c == '0) begin
					err_code_d = STAT_ZERO;
					state_d    = ST_ERR;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: if (mcnt_q == 2'd2) state_d = ST_DIVR_S;
			ST_DIVR_S: begin
				div_start = 1'b1;
				state_d   = ST_DIVR_W;
			end
			ST_DIVR_W: if (div_done) state_d = ST_CHK;
			ST_CHK: begin
				if (rate_c > {32'b0, obr_q}) begin
					err_code_d = STAT_RATE;
					state_d    = ST_ERR;
				end else begin
					state_d = (buf_cnt_q == '0) ? ST_FIN : ST_STEP;
				end
			end
			ST_STEP: state_d = (step_i_q == '0) ? ST_EMIT : ST_DIVC_S;
			ST_DIVC_S: begin
				div_start = 1'b1;
				state_d   = ST_DIVC_W;
			end
			ST_DIVC_W: if (div_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_space) begin
					out_load = 1'b1;
					state_d  = last_c ? ST_FIN : ST_STEP;
				end
			end
			ST_FIN: begin
				mem_we  = 1'b1;
				state_d = ST_BUF;
			end
			ST_BUF: begin
				if (buf_cnt_q == '1) begin
					err_code_d = STAT_OVF;
					state_d    = ST_ERR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				out_slot_d  = '0;
				out_nulls_d = '0;
				out_last_d  = 1'b1;
				out_stat_d  = err_code_q;
				if (out_space) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pcr_mem[mem_addr] <= mem_wpcr;
			pn_mem[mem_addr]  <= mem_wpn;
		end
	end

	always_ff @(posedge clk) begin
		old_pcr_q <= pcr_mem[pid_q];
		old_pn_q  <= pn_mem[pid_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && fq_valid) begin
			pid_q <= fq_data.pid;
			pcr_q <= fq_data.pcr;
		end
		if (state_q == ST_LOOK) begin
			delta_q <= delta_c;
			dpk_q   <= counter_q - old_pn_q;
			prod_q  <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_q + ({32'b0, 52'(dpk_q[16*mcnt_q +: 16]) * 52'(BitsClock)}
				<< (16 * mcnt_q));
		end
		if (state_q == ST_CHK) begin
			step_o_q <= {21'b0, 43'(obr_q) * 43'(PktBits)};
			step_i_q <= {21'b0, 43'(rate_c[31:0]) * 43'(PktBits)};
		end
		if (state_q == ST_STEP && step_i_q == '0) nulls_q <= '1;
		if (state_q == ST_DIVC_W && div_done) begin
			nulls_q <= (div_q[DvdW-1:32] != '0) ? '1 : div_q[31:0];
		end
		if (state_q != ST_ERR && state_d == ST_ERR) err_code_q <= err_code_d;
		if (out_load) begin
			slot_number   <= out_slot_d;
			null_count    <= out_nulls_d;
			last_of_flush <= out_last_d;
			status        <= out_stat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			obr_q       <= ObrReset;
			counter_q   <= '0;
			free_q      <= '0;
			used_q      <= '0;
			buf_cnt_q   <= '0;
			k_q         <= '0;
			mcnt_q      <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) obr_q <= cfg_wr_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_LOOK) mcnt_q <= '0;
			if (state_q == ST_MUL) mcnt_q <= mcnt_q + 2'd1;
			if (state_q == ST_CHK) k_q <= '0;
			if (state_q == ST_STEP) begin
				free_q <= free_q + step_o_q;
				used_q <= used_q + step_i_q;
			end
			if (state_q == ST_DIVC_W && div_done) used_q <= free_q - div_rem;
			if (state_q == ST_EMIT && out_load) k_q <= k_q + 1'b1;
			if (state_q == ST_FIN) begin
				free_q    <= free_q - used_q;
				used_q    <= '0;
				buf_cnt_q <= '0;
			end
			if (state_q == ST_BUF && buf_cnt_q != '1) begin
				buf_cnt_q <= buf_cnt_q + 1'b1;
				counter_q <= counter_q + 1'b1;
			end
			if (state_q == ST_ERR && out_load) halted_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	assign empty = ~out_valid_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag dropped");
	a_clear_no_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !fq_pop) else $error("item taken during clear");
	a_load_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pop)) else $error("result overwritten");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted_q) |-> !out_load) else $error("result after halt");
endmodule
